[sv/qost_pkg.sv]
package qost_pkg;

	localparam int CoordWidth = 16;
	localparam int AxisWidth  = CoordWidth + 1;
	localparam int ProdWidth  = CoordWidth + AxisWidth;
	localparam int ProjWidth  = ProdWidth + 1;
	localparam int NumCoords  = 8;
	localparam int NumCorners = 4;
	localparam int NumAxes    = 4;

	localparam logic ModeLoad = 1'b0;
	localparam logic ModeTest = 1'b1;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [AxisWidth-1:0]  axis_t;
	typedef logic signed [ProdWidth-1:0]  prod_t;
	typedef logic signed [ProjWidth-1:0]  proj_t;

	// order a.x, a.y, b.x, b.y, c.x, c.y, d.x, d.y
	typedef coord_t quad_t [NumCoords];

	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
	} pipe_ld_t;

endpackage

[sv/qost_axis_unit.sv]
module qost_axis_unit (
	input  logic              clk,
	input  qost_pkg::pipe_ld_t ld,
	input  qost_pkg::axis_t   axis_x,
	input  qost_pkg::axis_t   axis_y,
	input  qost_pkg::quad_t   ref_quad,
	input  qost_pkg::quad_t   test_quad,
	output logic              sep
);

	qost_pkg::prod_t ref_prod_s3  [qost_pkg::NumCoords];
	qost_pkg::prod_t test_prod_s3 [qost_pkg::NumCoords];
	qost_pkg::proj_t ref_lo_s4, ref_hi_s4, test_lo_s4, test_hi_s4;

	qost_pkg::proj_t ref_proj  [qost_pkg::NumCorners];
	qost_pkg::proj_t test_proj [qost_pkg::NumCorners];
	qost_pkg::proj_t ref_lo, ref_hi, test_lo, test_hi;

	// x coordinates against axis x, y coordinates against axis y
	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			for (int i = 0; i < qost_pkg::NumCoords; i++) begin
				if (i % 2 == 0) begin
					ref_prod_s3[i]  <= qost_pkg::prod_t'(ref_quad[i]) *
						qost_pkg::prod_t'(axis_x);
					test_prod_s3[i] <= qost_pkg::prod_t'(test_quad[i]) *
						qost_pkg::prod_t'(axis_x);
				end else begin
					ref_prod_s3[i]  <= qost_pkg::prod_t'(ref_quad[i]) *
						qost_pkg::prod_t'(axis_y);
					test_prod_s3[i] <= qost_pkg::prod_t'(test_quad[i]) *
						qost_pkg::prod_t'(axis_y);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < qost_pkg::NumCorners; k++) begin
			ref_proj[k]  = qost_pkg::proj_t'(ref_prod_s3[2*k]) +
				qost_pkg::proj_t'(ref_prod_s3[2*k+1]);
			test_proj[k] = qost_pkg::proj_t'(test_prod_s3[2*k]) +
				qost_pkg::proj_t'(test_prod_s3[2*k+1]);
		end
		ref_lo  = ref_proj[0];
		ref_hi  = ref_proj[0];
		test_lo = test_proj[0];
		test_hi = test_proj[0];
		for (int k = 1; k < qost_pkg::NumCorners; k++) begin
			if (ref_proj[k] < ref_lo)   ref_lo  = ref_proj[k];
			if (ref_proj[k] > ref_hi)   ref_hi  = ref_proj[k];
			if (test_proj[k] < test_lo) test_lo = test_proj[k];
			if (test_proj[k] > test_hi) test_hi = test_proj[k];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s4) begin
			ref_lo_s4  <= ref_lo;
			ref_hi_s4  <= ref_hi;
			test_lo_s4 <= test_lo;
			test_hi_s4 <= test_hi;
		end
	end

	// touching intervals do not separate
	assign sep = (ref_hi_s4 < test_lo_s4) || (test_hi_s4 < ref_lo_s4);

endmodule

[sv/quad_overlap_sat_test_unit.sv]
// Separating-axis overlap test for two four-corner rectangles. A request
// with mode 0 stores its corners as the reference rectangle and gives no
// result; it applies to every request accepted after it. A request with
// mode 1 is tested against the reference and gives one hit flag, 1 when
// the projections overlap or touch on both edge normals of each rectangle. Coordinates
// are signed fixed point with 4 fraction bits and all arithmetic is exact.
// One request is taken every cycle unless in_stall is high. A test request
// passes the input register and then the stages of axis subtract,
// multiply, projection sum with min/max, and interval compare into the
// output register. A stalled result holds only the full stages behind it.
// The reference rectangle is all zero after reset.
module quad_overlap_sat_test_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  qost_pkg::coord_t corner0_x,
	input  qost_pkg::coord_t corner0_y,
	input  qost_pkg::coord_t corner1_x,
	input  qost_pkg::coord_t corner1_y,
	input  qost_pkg::coord_t corner2_x,
	input  qost_pkg::coord_t corner2_y,
	input  qost_pkg::coord_t corner3_x,
	input  qost_pkg::coord_t corner3_y,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit
);

	qost_pkg::coord_t  ref_q [qost_pkg::NumCoords];
	qost_pkg::quad_t   in_quad;
	qost_pkg::quad_t   ref_s1, test_s1, ref_s2, test_s2;
	qost_pkg::axis_t   axis_x_s2 [qost_pkg::NumAxes];
	qost_pkg::axis_t   axis_y_s2 [qost_pkg::NumAxes];
	qost_pkg::pipe_ld_t ld;
	logic              v_s1, v_s2, v_s3, v_s4, out_valid_q, hit_q;
	logic              ld_out, ld_s4, ld_s3, ld_s2, ld_s1;
	logic              accept;
	logic [qost_pkg::NumAxes-1:0] sep;

	assign in_quad[0] = corner0_x;
	assign in_quad[1] = corner0_y;
	assign in_quad[2] = corner1_x;
	assign in_quad[3] = corner1_y;
	assign in_quad[4] = corner2_x;
	assign in_quad[5] = corner2_y;
	assign in_quad[6] = corner3_x;
	assign in_quad[7] = corner3_y;

	// a stage loads when empty or when the next one loads
	assign ld_out = !out_valid_q || !out_stall;
	assign ld_s4  = !v_s4 || ld_out;
	assign ld_s3  = !v_s3 || ld_s4;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;
	assign in_stall = !ld_s1;
	assign accept = in_valid && ld_s1;
	assign ld.ld_s3 = ld_s3;
	assign ld.ld_s4 = ld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qost_pkg::NumCoords; i++) ref_q[i] <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && mode == qost_pkg::ModeLoad) begin
				for (int i = 0; i < qost_pkg::NumCoords; i++) ref_q[i] <= in_quad[i];
			end
			if (ld_s1)  v_s1 <= accept && mode == qost_pkg::ModeTest;
			if (ld_s2)  v_s2 <= v_s1;
			if (ld_s3)  v_s3 <= v_s2;
			if (ld_s4)  v_s4 <= v_s3;
			if (ld_out) out_valid_q <= v_s4;
		end
	end

	// reference snapshot taken with the request
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int i = 0; i < qost_pkg::NumCoords; i++) begin
				ref_s1[i]  <= ref_q[i];
				test_s1[i] <= in_quad[i];
			end
		end
	end

	// normals (-dy, dx) of edges b-a and b-c of each rectangle
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			for (int i = 0; i < qost_pkg::NumCoords; i++) begin
				ref_s2[i]  <= ref_s1[i];
				test_s2[i] <= test_s1[i];
			end
			axis_x_s2[0] <= qost_pkg::axis_t'(ref_s1[1]) - qost_pkg::axis_t'(ref_s1[3]);
			axis_y_s2[0] <= qost_pkg::axis_t'(ref_s1[2]) - qost_pkg::axis_t'(ref_s1[0]);
			axis_x_s2[1] <= qost_pkg::axis_t'(ref_s1[5]) - qost_pkg::axis_t'(ref_s1[3]);
			axis_y_s2[1] <= qost_pkg::axis_t'(ref_s1[2]) - qost_pkg::axis_t'(ref_s1[4]);
			axis_x_s2[2] <= qost_pkg::axis_t'(test_s1[1]) - qost_pkg::axis_t'(test_s1[3]);
			axis_y_s2[2] <= qost_pkg::axis_t'(test_s1[2]) - qost_pkg::axis_t'(test_s1[0]);
			axis_x_s2[3] <= qost_pkg::axis_t'(test_s1[5]) - qost_pkg::axis_t'(test_s1[3]);
			axis_y_s2[3] <= qost_pkg::axis_t'(test_s1[2]) - qost_pkg::axis_t'(test_s1[4]);
		end
	end

	for (genvar g = 0; g < qost_pkg::NumAxes; g++) begin : g_axis
		qost_axis_unit u_axis (
			.clk       (clk),
			.ld        (ld),
			.axis_x    (axis_x_s2[g]),
			.axis_y    (axis_y_s2[g]),
			.ref_quad  (ref_s2),
			.test_quad (test_s2),
			.sep       (sep[g])
		);
	end

	always_ff @(posedge clk) begin
		if (ld_out) hit_q <= !(|sep);
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	a_load_stores: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == qost_pkg::ModeLoad) |=>
			(ref_q[0] == $past(corner0_x) && ref_q[7] == $past(corner3_y)))
		else $error("reference not stored on load request");

	a_test_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == qost_pkg::ModeTest) |=> v_s1)
		else $error("test request lost at pipeline entry");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_valid_q && out_stall))
		else $error("input stalled with a bubble in the pipeline");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !v_s4) |=> !out_valid_q)
		else $error("result repeated after being taken");

endmodule

[dv/tb_quad_overlap_sat_test_unit.sv]
`timescale 1ns / 100ps

module tb_quad_overlap_sat_test_unit;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic             mode      = qost_pkg::ModeLoad;
	qost_pkg::coord_t corner0_x = '0;
	qost_pkg::coord_t corner0_y = '0;
	qost_pkg::coord_t corner1_x = '0;
	qost_pkg::coord_t corner1_y = '0;
	qost_pkg::coord_t corner2_x = '0;
	qost_pkg::coord_t corner2_y = '0;
	qost_pkg::coord_t corner3_x = '0;
	qost_pkg::coord_t corner3_y = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             hit;

	quad_overlap_sat_test_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.corner0_x (corner0_x),
		.corner0_y (corner0_y),
		.corner1_x (corner1_x),
		.corner1_y (corner1_y),
		.corner2_x (corner2_x),
		.corner2_y (corner2_y),
		.corner3_x (corner3_x),
		.corner3_y (corner3_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit)
	);

	qost_pkg::quad_t stored_ref;
	bit    expected_hits[$];
	int    fail_count     = 0;
	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;
	bit    hit_due;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// min and max of the four corner projections onto one axis
	function automatic void quad_span(input qost_pkg::quad_t q, input longint ax,
			input longint ay, output longint lo, output longint hi);
		longint p;
		lo = longint'(q[0]) * ax + longint'(q[1]) * ay;
		hi = lo;
		for (int k = 1; k < qost_pkg::NumCorners; k++) begin
			p = longint'(q[2*k]) * ax + longint'(q[2*k+1]) * ay;
			if (p < lo) lo = p;
			if (p > hi) hi = p;
		end
	endfunction

	function automatic bit quads_overlap(input qost_pkg::quad_t r, input qost_pkg::quad_t o);
		longint axes[8];
		longint rlo, rhi, olo, ohi;
		// normals of edges b-a and b-c of both rectangles
		axes[0] = -(longint'(r[3]) - longint'(r[1])); axes[1] = longint'(r[2]) - longint'(r[0]);
		axes[2] = -(longint'(r[3]) - longint'(r[5])); axes[3] = longint'(r[2]) - longint'(r[4]);
		axes[4] = -(longint'(o[3]) - longint'(o[1])); axes[5] = longint'(o[2]) - longint'(o[0]);
		axes[6] = -(longint'(o[3]) - longint'(o[5])); axes[7] = longint'(o[2]) - longint'(o[4]);
		for (int i = 0; i < qost_pkg::NumAxes; i++) begin
			quad_span(r, axes[2*i], axes[2*i+1], rlo, rhi);
			quad_span(o, axes[2*i], axes[2*i+1], olo, ohi);
			if (rhi < olo || ohi < rlo) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic qost_pkg::quad_t build_quad(input int ax, input int ay,
			input int bx, input int by, input int cx, input int cy, input int dx, input int dy);
		qost_pkg::quad_t q;
		q[0] = qost_pkg::coord_t'(ax); q[1] = qost_pkg::coord_t'(ay);
		q[2] = qost_pkg::coord_t'(bx); q[3] = qost_pkg::coord_t'(by);
		q[4] = qost_pkg::coord_t'(cx); q[5] = qost_pkg::coord_t'(cy);
		q[6] = qost_pkg::coord_t'(dx); q[7] = qost_pkg::coord_t'(dy);
		return q;
	endfunction

	function automatic int signed_rand(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// mostly proper rotated rectangles, some raw bit patterns and extremes
	function automatic qost_pkg::quad_t random_quad();
		qost_pkg::quad_t q;
		int    kind, span, m;
		int    cx, cy, ux, uy, vx, vy;
		int    extremes[4];
		kind = $urandom_range(9);
		extremes[0] = -32768; extremes[1] = 32767; extremes[2] = 0; extremes[3] = -1;
		if (kind == 0) begin
			for (int i = 0; i < qost_pkg::NumCoords; i++) q[i] = qost_pkg::coord_t'($urandom);
			return q;
		end
		if (kind == 1) begin
			for (int i = 0; i < qost_pkg::NumCoords; i++)
				q[i] = qost_pkg::coord_t'(extremes[$urandom_range(3)]);
			return q;
		end
		case ($urandom_range(2))
			0: span = 64;
			1: span = 2000;
			default: span = 12000;
		endcase
		cx = signed_rand(span);
		cy = signed_rand(span);
		ux = (kind == 2) ? 0 : signed_rand(span / 3);
		uy = (kind == 2) ? 0 : signed_rand(span / 3);
		m  = $urandom_range(1, 3);
		vx = -(uy * m) / 2;
		vy = (ux * m) / 2;
		return build_quad(cx - ux - vx, cy - uy - vy, cx + ux - vx, cy + uy - vy,
			cx + ux + vx, cy + uy + vy, cx - ux + vx, cy - uy + vy);
	endfunction

	task automatic send_request(input logic m, input qost_pkg::quad_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		corner0_x <= q[0]; corner0_y <= q[1];
		corner1_x <= q[2]; corner1_y <= q[3];
		corner2_x <= q[4]; corner2_y <= q[5];
		corner3_x <= q[6]; corner3_y <= q[7];
		do @(posedge clk); while (in_stall);
		if (m == qost_pkg::ModeLoad) stored_ref = q;
		else expected_hits.push_back(quads_overlap(stored_ref, q));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
	endtask

	// results checked in acceptance order
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("%0t: unexpected result hit=%b", $realtime, hit);
			end else begin
				hit_due = expected_hits.pop_front();
				if (hit !== hit_due) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: hit mismatch, expected %b got %b", $realtime, hit_due, hit);
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	task automatic test_before_load();
		send_request(qost_pkg::ModeTest, build_quad(0, 0, 0, 0, 0, 0, 0, 0));
		send_request(qost_pkg::ModeTest,
			build_quad(1000, 1000, 2000, 1000, 2000, 2000, 1000, 2000));
		send_request(qost_pkg::ModeTest, build_quad(-16, -16, 16, -16, 16, 16, -16, 16));
		send_request(qost_pkg::ModeTest, build_quad(0, 5, 5, 0, 10, 5, 5, 10));
	endtask

	task automatic test_extremes();
		send_request(qost_pkg::ModeLoad,
			build_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
		send_request(qost_pkg::ModeTest,
			build_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
		send_request(qost_pkg::ModeTest,
			build_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_request(qost_pkg::ModeTest,
			build_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_request(qost_pkg::ModeLoad,
			build_quad(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767));
		send_request(qost_pkg::ModeTest,
			build_quad(21845, -21846, 21845, -21846, -21846, 21845, -21846, 21845));
		send_request(qost_pkg::ModeTest,
			build_quad(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768));
	endtask

	task automatic test_touching();
		send_request(qost_pkg::ModeLoad, build_quad(0, 0, 16, 0, 16, 16, 0, 16));
		send_request(qost_pkg::ModeTest, build_quad(16, 0, 32, 0, 32, 16, 16, 16));
		send_request(qost_pkg::ModeTest, build_quad(17, 0, 33, 0, 33, 16, 17, 16));
		// diamond meeting the square's right edge at one point, then one lsb off
		send_request(qost_pkg::ModeTest, build_quad(24, 0, 32, 8, 24, 16, 16, 8));
		send_request(qost_pkg::ModeTest, build_quad(25, 0, 33, 8, 25, 16, 17, 8));
		send_request(qost_pkg::ModeTest, build_quad(-8, -8, 0, -16, 8, -8, 0, 0));
	endtask

	task automatic test_degenerate();
		send_request(qost_pkg::ModeTest, build_quad(4, 4, 4, 4, 8, 8, 0, 8));
		send_request(qost_pkg::ModeLoad, build_quad(5, 5, 5, 5, 5, 5, 5, 5));
		send_request(qost_pkg::ModeTest, build_quad(0, 0, 10, 0, 10, 10, 0, 10));
		send_request(qost_pkg::ModeTest, build_quad(6, 0, 10, 0, 10, 10, 6, 10));
		send_request(qost_pkg::ModeTest, build_quad(5, 5, 5, 5, 5, 5, 5, 5));
		send_request(qost_pkg::ModeTest, build_quad(-3, 2, -3, 2, -3, 2, -3, 2));
	endtask

	task automatic test_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			send_request(($urandom_range(3) == 0) ? qost_pkg::ModeLoad : qost_pkg::ModeTest,
				random_quad());
			if (n == count / 2) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_load();
		test_extremes();
		test_touching();
		test_degenerate();
		wait_drained();
		test_random(530, 36, 61);
		test_random(530, 61, 36);
		test_random(540, 0, 0);
		repeat (12) @(posedge clk);
		if (fail_count == 0 && expected_hits.size() == 0)
			$display("quad_overlap_sat_test_unit test passed");
		else
			$display("quad_overlap_sat_test_unit test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("quad_overlap_sat_test_unit test failed");
		$finish;
	end

endmodule
